[src/blm_pkg.sv]
// Package for the battery level monitor: controller/datapath handshake types,
// register indexes, divider sizes and the discharge curve table.
// Depends on nothing; every other file imports it.
package blm_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACC,
    ST_CLOSE,
    ST_BDIV,
    ST_GAIN,
    ST_FLAG,
    ST_EMA_MUL,
    ST_EMA_UPD,
    ST_MVOUT,
    ST_SEG,
    ST_CPROD,
    ST_CSTART,
    ST_CDIV,
    ST_PCT,
    ST_DONE
  } blm_state_t;

  typedef struct packed {
    logic capture;
    logic acc;
    logic set_empty;
    logic bdiv_start;
    logic gain;
    logic flag;
    logic ema_mul;
    logic ema_upd;
    logic mvout;
    logic seg;
    logic cprod;
    logic cdiv_start;
    logic pct;
    logic load_out;
  } blm_cmd_t;

  typedef struct packed {
    logic last;
    logic good_zero;
    logic div_done;
    logic out_free;
  } blm_sts_t;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 14;

  localparam logic [CFG_IDX_W-1:0] REG_CHARGE_ON  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHARGE_OFF = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EMA_ALPHA  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIV_GAIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RAW_MODE   = 3'd4;

  localparam logic [13:0] MV_MAX = 14'd16383;
  localparam logic [8:0] ALPHA_MAX = 9'd256;
  localparam logic [11:0] RAW_FULL_MV = 12'd3300;
  localparam logic [11:0] RAW_FULL_CODE = 12'd4095;

  localparam int DIV_NW = 21;
  localparam int DIV_DW = 14;
  localparam int DIV_CW = 5;

  localparam int CURVE_POINTS = 12;
  localparam int CURVE_IDX_W = 4;

  function automatic logic [13:0] curve_mv(input logic [CURVE_IDX_W-1:0] i);
    logic [13:0] v;
    unique case (i)
      4'd0:    v = 14'd4200;
      4'd1:    v = 14'd4060;
      4'd2:    v = 14'd3980;
      4'd3:    v = 14'd3920;
      4'd4:    v = 14'd3870;
      4'd5:    v = 14'd3820;
      4'd6:    v = 14'd3790;
      4'd7:    v = 14'd3770;
      4'd8:    v = 14'd3740;
      4'd9:    v = 14'd3680;
      4'd10:   v = 14'd3500;
      4'd11:   v = 14'd3300;
      default: v = 14'd3300;
    endcase
    return v;
  endfunction

  function automatic logic [6:0] curve_pct(input logic [CURVE_IDX_W-1:0] i);
    logic [6:0] v;
    unique case (i)
      4'd0:    v = 7'd100;
      4'd1:    v = 7'd90;
      4'd2:    v = 7'd80;
      4'd3:    v = 7'd70;
      4'd4:    v = 7'd60;
      4'd5:    v = 7'd50;
      4'd6:    v = 7'd40;
      4'd7:    v = 7'd30;
      4'd8:    v = 7'd20;
      4'd9:    v = 7'd10;
      4'd10:   v = 7'd5;
      4'd11:   v = 7'd0;
      default: v = 7'd0;
    endcase
    return v;
  endfunction

endpackage

[src/blm_div.sv]
// Shared restoring divider, one quotient bit per cycle.
// Depends on blm_pkg for the operand widths.
module blm_div
  import blm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_NW-1:0] num,
  input  logic [DIV_DW-1:0] den,
  output logic              done,
  output logic [DIV_NW-1:0] quot
);

  logic              busy_r;
  logic              done_r;
  logic [DIV_CW-1:0] cnt_r;
  logic [DIV_DW-1:0] rem_r;
  logic [DIV_DW-1:0] rem_nxt;
  logic [DIV_NW-1:0] q_r;
  logic [DIV_DW-1:0] den_r;
  logic [DIV_DW:0]   rem_sh;
  logic              ge;

  always_comb begin
    rem_sh = {rem_r, q_r[DIV_NW-1]};
    ge = rem_sh >= {1'b0, den_r};
    if (ge) begin
      rem_nxt = DIV_DW'(rem_sh - {1'b0, den_r});
    end else begin
      rem_nxt = rem_sh[DIV_DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CW'(DIV_NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r <= {q_r[DIV_NW-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

[src/blm_dp.sv]
// Datapath: configuration registers, burst accumulator, smoothing, curve
// lookup and the result register. Depends on blm_pkg and blm_div.
module blm_dp
  import blm_pkg::*;
#(
  parameter int BURST_SAMPLES = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  blm_cmd_t              cmd,
  output blm_sts_t              sts,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [11:0]           in_sample,
  input  logic                  in_sample_ok,
  input  logic                  in_last_in_burst,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_valid_res,
  output logic [13:0]           out_battery_mv,
  output logic [6:0]            out_percent,
  output logic                  out_charging
);

  localparam int CNT_W = $clog2(BURST_SAMPLES + 1);
  localparam int SUM_W = 12 + CNT_W;

  logic [13:0] charge_on_r;
  logic [13:0] charge_off_r;
  logic [8:0]  alpha_r;
  logic [2:0]  gain_r;
  logic        raw_mode_r;

  logic [11:0]      sample_r;
  logic             ok_r;
  logic             last_r;
  logic [23:0]      prod_r;
  logic [SUM_W-1:0] sum_r;
  logic [CNT_W-1:0] cnt_r;

  logic [13:0] inst_r;
  logic        chg_r;
  logic        seeded_r;
  logic        seed_now_r;
  logic        up_r;
  logic [21:0] diff_r;
  logic [30:0] eprod_r;
  logic [21:0] smooth_r;
  logic [13:0] mvo_r;

  logic [CURVE_IDX_W-1:0] idx_r;
  logic                   top_r;
  logic                   bot_r;
  logic [20:0]            cnum_r;
  logic [13:0]            cden_r;
  logic [6:0]             plo_r;
  logic                   zero_r;

  logic        res_valid_r;
  logic [13:0] res_mv_r;
  logic [6:0]  res_pct_r;
  logic        res_chg_r;
  logic        out_valid_r;

  logic              div_start;
  logic [DIV_NW-1:0] div_num;
  logic [DIV_DW-1:0] div_den;
  logic              div_done;
  logic [DIV_NW-1:0] div_quot;

  logic [11:0]            raw_est;
  logic [24:0]            raw_rem;
  logic [11:0]            mv_c;
  logic [14:0]            inst_c;
  logic                   chg_c;
  logic [21:0]            target_c;
  logic [8:0]             alpha_c;
  logic [31:0]            delta_sum;
  logic [21:0]            delta_c;
  logic [22:0]            mv_round;
  logic [CURVE_IDX_W-1:0] idx_c;
  logic [CURVE_IDX_W-1:0] idx_hi;
  logic [13:0]            seg_lo;
  logic [13:0]            seg_span;
  logic [6:0]             seg_spct;
  logic [6:0]             pct_c;

  // Raw codes are scaled by 3300/4095: the quotient estimate from the
  // reciprocal series is at most one low, so one correction step suffices.
  always_comb begin
    raw_est = 12'((25'(prod_r) + 25'(prod_r[23:12])) >> 12);
    raw_rem = 25'(prod_r) + 25'(raw_est) - {1'b0, raw_est, 12'd0};
    if (!raw_mode_r) begin
      mv_c = sample_r;
    end else if (raw_rem >= 25'(RAW_FULL_CODE)) begin
      mv_c = raw_est + 1'b1;
    end else begin
      mv_c = raw_est;
    end
  end

  always_comb begin
    inst_c = 15'(div_quot[11:0] * gain_r);
    priority if (inst_r >= charge_on_r) begin
      chg_c = 1'b1;
    end else if (inst_r < charge_off_r) begin
      chg_c = 1'b0;
    end else begin
      chg_c = chg_r;
    end
    target_c = {inst_r, 8'd0};
    alpha_c = (alpha_r > ALPHA_MAX) ? ALPHA_MAX : alpha_r;
    delta_sum = 32'(eprod_r) + 32'd128;
    delta_c = 22'(delta_sum[31:8]);
    mv_round = 23'(smooth_r) + 23'd128;
  end

  always_comb begin
    idx_c = CURVE_IDX_W'(CURVE_POINTS - 1);
    for (int i = CURVE_POINTS - 1; i >= 1; i--) begin
      if (mvo_r >= curve_mv(CURVE_IDX_W'(i))) begin
        idx_c = CURVE_IDX_W'(i);
      end
    end
    idx_hi = idx_r - 1'b1;
    seg_lo = curve_mv(idx_r);
    seg_span = curve_mv(idx_hi) - seg_lo;
    seg_spct = curve_pct(idx_hi) - curve_pct(idx_r);
    priority if (top_r) begin
      pct_c = 7'd100;
    end else if (bot_r) begin
      pct_c = 7'd0;
    end else if (zero_r) begin
      pct_c = plo_r;
    end else begin
      pct_c = plo_r + div_quot[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      charge_on_r <= 14'd4000;
      charge_off_r <= 14'd3900;
      alpha_r <= 9'd77;
      gain_r <= 3'd2;
      raw_mode_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CHARGE_ON:  charge_on_r <= cfg_data;
        REG_CHARGE_OFF: charge_off_r <= cfg_data;
        REG_EMA_ALPHA:  alpha_r <= cfg_data[8:0];
        REG_DIV_GAIN:   gain_r <= cfg_data[2:0];
        REG_RAW_MODE:   raw_mode_r <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample_r <= in_sample;
      ok_r <= in_sample_ok;
      last_r <= in_last_in_burst;
      prod_r <= 24'(in_sample * RAW_FULL_MV);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
      chg_r <= 1'b0;
      seeded_r <= 1'b0;
      smooth_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.acc && ok_r && (cnt_r < CNT_W'(BURST_SAMPLES))) begin
        sum_r <= sum_r + SUM_W'(mv_c);
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.gain || cmd.set_empty) begin
        sum_r <= '0;
        cnt_r <= '0;
      end
      if (cmd.flag) begin
        chg_r <= chg_c;
      end
      if (cmd.ema_upd) begin
        if (seed_now_r) begin
          smooth_r <= target_c;
          seeded_r <= 1'b1;
        end else if (up_r) begin
          smooth_r <= smooth_r + delta_c;
        end else begin
          smooth_r <= smooth_r - delta_c;
        end
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.gain) begin
      inst_r <= (inst_c > 15'(MV_MAX)) ? MV_MAX : inst_c[13:0];
    end
    if (cmd.flag) begin
      seed_now_r <= !seeded_r || (chg_c != chg_r);
      up_r <= target_c >= smooth_r;
      diff_r <= (target_c >= smooth_r) ? target_c - smooth_r : smooth_r - target_c;
    end
    if (cmd.ema_mul) begin
      eprod_r <= 31'(alpha_c * diff_r);
    end
    if (cmd.mvout) begin
      mvo_r <= (mv_round[22:8] > 15'(MV_MAX)) ? MV_MAX : mv_round[21:8];
    end
    if (cmd.seg) begin
      idx_r <= idx_c;
      top_r <= mvo_r >= curve_mv('0);
      bot_r <= mvo_r <= curve_mv(CURVE_IDX_W'(CURVE_POINTS - 1));
    end
    if (cmd.cprod) begin
      cnum_r <= 21'((mvo_r - seg_lo) * seg_spct);
      cden_r <= seg_span;
      plo_r <= curve_pct(idx_r);
      zero_r <= seg_span == 14'd0;
    end
    if (cmd.set_empty) begin
      res_valid_r <= 1'b0;
      res_mv_r <= '0;
      res_pct_r <= '0;
      res_chg_r <= 1'b0;
    end
    if (cmd.pct) begin
      res_valid_r <= 1'b1;
      res_mv_r <= mvo_r;
      res_pct_r <= pct_c;
      res_chg_r <= chg_r;
    end
    if (cmd.load_out) begin
      out_valid_res <= res_valid_r;
      out_battery_mv <= res_mv_r;
      out_percent <= res_pct_r;
      out_charging <= res_chg_r;
    end
  end

  assign div_start = cmd.bdiv_start || cmd.cdiv_start;
  assign div_num = cmd.bdiv_start ? DIV_NW'(sum_r) : cnum_r;
  assign div_den = cmd.bdiv_start ? DIV_DW'(cnt_r) : cden_r;

  blm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign sts.last = last_r;
  assign sts.good_zero = cnt_r == '0;
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

endmodule

[src/blm_ctrl.sv]
// Controller state machine that sequences the datapath for each word.
// Depends on blm_pkg for the state, command and status types.
module blm_ctrl
  import blm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  blm_sts_t sts,
  output blm_cmd_t cmd
);

  blm_state_t state_r;
  blm_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd.acc = 1'b1;
        state_nxt = sts.last ? ST_CLOSE : ST_IDLE;
      end
      ST_CLOSE: begin
        if (sts.good_zero) begin
          cmd.set_empty = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          cmd.bdiv_start = 1'b1;
          state_nxt = ST_BDIV;
        end
      end
      ST_BDIV: begin
        if (sts.div_done) begin
          state_nxt = ST_GAIN;
        end
      end
      ST_GAIN: begin
        cmd.gain = 1'b1;
        state_nxt = ST_FLAG;
      end
      ST_FLAG: begin
        cmd.flag = 1'b1;
        state_nxt = ST_EMA_MUL;
      end
      ST_EMA_MUL: begin
        cmd.ema_mul = 1'b1;
        state_nxt = ST_EMA_UPD;
      end
      ST_EMA_UPD: begin
        cmd.ema_upd = 1'b1;
        state_nxt = ST_MVOUT;
      end
      ST_MVOUT: begin
        cmd.mvout = 1'b1;
        state_nxt = ST_SEG;
      end
      ST_SEG: begin
        cmd.seg = 1'b1;
        state_nxt = ST_CPROD;
      end
      ST_CPROD: begin
        cmd.cprod = 1'b1;
        state_nxt = ST_CSTART;
      end
      ST_CSTART: begin
        cmd.cdiv_start = 1'b1;
        state_nxt = ST_CDIV;
      end
      ST_CDIV: begin
        if (sts.div_done) begin
          state_nxt = ST_PCT;
        end
      end
      ST_PCT: begin
        cmd.pct = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[src/battery_level_monitor.sv]
// Battery level monitor. A word that does not close a burst is only captured
// and accumulated. A closing word with at least one good sample spends most
// of its time in two passes through the shared 21-step bit-serial divider (burst
// mean, then curve interpolation); a closing word on an empty burst skips the
// divider. The result sits in an output register, so the next word is taken
// while a result waits, and only a second result stalls behind it.
// Depends on blm_pkg, blm_ctrl, blm_dp and blm_div.
module battery_level_monitor
  import blm_pkg::*;
#(
  parameter int BURST_SAMPLES = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [11:0]           in_sample,
  input  logic                  in_sample_ok,
  input  logic                  in_last_in_burst,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_valid_res,
  output logic [13:0]           out_battery_mv,
  output logic [6:0]            out_percent,
  output logic                  out_charging,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  blm_cmd_t cmd;
  blm_sts_t sts;

  assign cfg_ready = 1'b1;

  blm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  blm_dp #(
    .BURST_SAMPLES (BURST_SAMPLES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_sample        (in_sample),
    .in_sample_ok     (in_sample_ok),
    .in_last_in_burst (in_last_in_burst),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_valid_res    (out_valid_res),
    .out_battery_mv   (out_battery_mv),
    .out_percent      (out_percent),
    .out_charging     (out_charging)
  );

endmodule

[verif/testbench.sv]
// Testbench for battery_level_monitor: drives ADC sample bursts and register writes,
// predicts every reading with its own fuel gauge model and checks the results.
// Depends on blm_pkg and the battery_level_monitor RTL.
module testbench
  import blm_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned WORDS_PER_PHASE = 168;

  typedef struct packed {
    logic        valid_res;
    logic [13:0] battery_mv;
    logic [6:0]  percent;
    logic        charging;
  } reading_t;

  class fuel_gauge_board;
    localparam int unsigned FULL_BURST = 16;
    localparam int unsigned KNEES = 12;

    logic [13:0] on_mv;
    logic [13:0] off_mv;
    logic [8:0]  alpha;
    logic [2:0]  gain;
    logic        raw;

    logic [15:0] burst_sum;
    logic [4:0]  good_cnt;
    logic [21:0] avg_q8;
    bit          seeded;
    bit          charging;

    int unsigned knee_mv[KNEES];
    int unsigned knee_pct[KNEES];
    reading_t    due_readings[$];
    int unsigned failures;

    function new();
      knee_mv = '{4200, 4060, 3980, 3920, 3870, 3820, 3790, 3770, 3740, 3680, 3500, 3300};
      knee_pct = '{100, 90, 80, 70, 60, 50, 40, 30, 20, 10, 5, 0};
      on_mv = 14'd4000;
      off_mv = 14'd3900;
      alpha = 9'd77;
      gain = 3'd2;
      raw = 1'b0;
      burst_sum = '0;
      good_cnt = '0;
      avg_q8 = '0;
      seeded = 1'b0;
      charging = 1'b0;
      failures = 0;
    endfunction

    task report(string what);
      $display("%0t ns: mismatch: %s", $time, what);
      failures++;
    endtask

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_CHARGE_ON:  on_mv = data[13:0];
        REG_CHARGE_OFF: off_mv = data[13:0];
        REG_EMA_ALPHA:  alpha = data[8:0];
        REG_DIV_GAIN:   gain = data[2:0];
        REG_RAW_MODE:   raw = data[0];
        default: ;
      endcase
    endfunction

    function int unsigned charge_percent(int unsigned mv);
      int unsigned i;
      if (mv >= knee_mv[0]) return 100;
      if (mv <= knee_mv[KNEES-1]) return 0;
      for (i = 1; i < KNEES; i++) begin
        if (mv >= knee_mv[i]) begin
          if (knee_mv[i-1] == knee_mv[i]) return knee_pct[i];
          return knee_pct[i] + (mv - knee_mv[i]) * (knee_pct[i-1] - knee_pct[i]) /
                 (knee_mv[i-1] - knee_mv[i]);
        end
      end
      return 0;
    endfunction

    function void note_sample(logic [11:0] s, logic ok, logic last);
      int unsigned mv, inst, aim_q8, step, a, shown;
      bit was;
      reading_t r;
      if (ok && good_cnt < FULL_BURST) begin
        mv = raw ? int'(s) * int'(RAW_FULL_MV) / int'(RAW_FULL_CODE) : int'(s);
        burst_sum = burst_sum + mv[15:0];
        good_cnt = good_cnt + 5'd1;
      end
      if (!last) return;
      if (good_cnt == 0) begin
        burst_sum = '0;
        due_readings.push_back('0);
        return;
      end
      inst = (int'(burst_sum) / int'(good_cnt)) * int'(gain);
      if (inst > MV_MAX) inst = MV_MAX;
      burst_sum = '0;
      good_cnt = '0;

      was = charging;
      if (inst >= on_mv) charging = 1'b1;
      else if (inst < off_mv) charging = 1'b0;
      if (charging != was) seeded = 1'b0;

      aim_q8 = inst << 8;
      if (!seeded) begin
        avg_q8 = aim_q8[21:0];
        seeded = 1'b1;
      end else begin
        a = (alpha > ALPHA_MAX) ? ALPHA_MAX : alpha;
        if (aim_q8 >= avg_q8) begin
          step = (a * (aim_q8 - avg_q8) + 128) >> 8;
          avg_q8 = avg_q8 + step[21:0];
        end else begin
          step = (a * (avg_q8 - aim_q8) + 128) >> 8;
          avg_q8 = avg_q8 - step[21:0];
        end
      end

      shown = (int'(avg_q8) + 128) >> 8;
      if (shown > MV_MAX) shown = MV_MAX;
      r.valid_res = 1'b1;
      r.battery_mv = shown[13:0];
      r.percent = 7'(charge_percent(shown));
      r.charging = charging;
      due_readings.push_back(r);
    endfunction

    function int unsigned pending_count();
      return due_readings.size();
    endfunction

    task check_reading(logic v, logic [13:0] mv, logic [6:0] pct, logic chg);
      reading_t want;
      if (due_readings.size() == 0) begin
        report($sformatf("reading with none expected (valid_res %0d, mv %0d)", v, mv));
        return;
      end
      want = due_readings.pop_front();
      if (v !== want.valid_res)
        report($sformatf("valid_res got %0d, want %0d", v, want.valid_res));
      if (mv !== want.battery_mv)
        report($sformatf("battery_mv got %0d, want %0d", mv, want.battery_mv));
      if (pct !== want.percent)
        report($sformatf("percent got %0d, want %0d", pct, want.percent));
      if (chg !== want.charging)
        report($sformatf("charging got %0d, want %0d", chg, want.charging));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [11:0] in_sample = '0;
  logic in_sample_ok = 1'b0;
  logic in_last_in_burst = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_valid_res;
  logic [13:0] out_battery_mv;
  logic [6:0] out_percent;
  logic out_charging;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  fuel_gauge_board gauge;
  int unsigned idle_pct = 28;
  int unsigned words_sent = 0;
  int unsigned quiet_cycles = 0;

  battery_level_monitor dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample        (in_sample),
    .in_sample_ok     (in_sample_ok),
    .in_last_in_burst (in_last_in_burst),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_valid_res    (out_valid_res),
    .out_battery_mv   (out_battery_mv),
    .out_percent      (out_percent),
    .out_charging     (out_charging),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      gauge.check_reading(out_valid_res, out_battery_mv, out_percent, out_charging);
    out_stall <= ($urandom_range(99) < idle_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(logic [11:0] s, logic ok, logic last);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_sample <= s;
    in_sample_ok <= ok;
    in_last_in_burst <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    gauge.note_sample(s, ok, last);
    words_sent++;
  endtask

  task automatic send_burst();
    int kind, len, aim, per, i;
    bit all_bad;
    kind = $urandom_range(99);
    if (kind < 10) begin
      len = $urandom_range(1, 8);
      for (i = 0; i < len; i++)
        send_word(12'($urandom_range(4095)), 1'($urandom_range(1)),
                  (i == len - 1) || ($urandom_range(7) == 0));
      return;
    end
    len = (kind < 25) ? $urandom_range(15, 20) : $urandom_range(1, 6);
    case ($urandom_range(4))
      0, 1, 2: aim = $urandom_range(3200, 4300);
      3:       aim = int'($urandom_range(1) ? gauge.on_mv : gauge.off_mv)
                     + int'($urandom_range(120)) - 60;
      default: aim = -1;
    endcase
    all_bad = ($urandom_range(19) == 0);
    for (i = 0; i < len; i++) begin
      if (aim < 0 || gauge.gain == 0) begin
        per = $urandom_range(4095);
      end else begin
        per = aim / int'(gauge.gain);
        if (gauge.raw) per = per * int'(RAW_FULL_CODE) / int'(RAW_FULL_MV);
        per = per + int'($urandom_range(40)) - 20;
      end
      if (per < 0) per = 0;
      if (per > 4095) per = 4095;
      send_word(per[11:0], !all_bad && ($urandom_range(9) != 0), i == len - 1);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (gauge.pending_count() != 0);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    gauge.set_register(idx, data);
  endtask

  task automatic apply_settings(logic [13:0] on_v, logic [13:0] off_v, logic [8:0] alpha_v,
                                logic [2:0] gain_v, logic raw_v, bit garble);
    logic [CFG_DATA_W-1:0] extra;
    int k;
    extra = garble ? CFG_DATA_W'($urandom) : '0;
    wait_drained();
    for (k = int'(REG_RAW_MODE) + 1; k < (1 << CFG_IDX_W); k++)
      write_register(CFG_IDX_W'(k), CFG_DATA_W'($urandom));
    write_register(REG_EMA_ALPHA, {extra[13:9], alpha_v});
    write_register(REG_CHARGE_ON, on_v);
    write_register(REG_DIV_GAIN, {extra[13:3], gain_v});
    write_register(REG_CHARGE_OFF, off_v);
    write_register(REG_RAW_MODE, {extra[13:1], raw_v});
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase();
    int unsigned stop_at;
    stop_at = words_sent + WORDS_PER_PHASE;
    while (words_sent < stop_at) send_burst();
  endtask

  initial begin
    int phase, k;
    logic [13:0] on_v, off_v;
    gauge = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(12'd4095, 1'b0, 1'b1);
    send_word(12'd4095, 1'b1, 1'b1);
    send_word(12'd0, 1'b1, 1'b1);
    send_word(12'd2100, 1'b1, 1'b1);
    send_word(12'd1960, 1'b1, 1'b1);
    send_word(12'd1940, 1'b1, 1'b0);
    send_word(12'd0, 1'b0, 1'b0);
    send_word(12'd1800, 1'b1, 1'b1);
    for (k = 0; k < 16; k++) send_word(12'(1900 + k), 1'b1, 1'b0);
    send_word(12'd4095, 1'b1, 1'b1);

    apply_settings(14'd16383, 14'd0, 9'd0, 3'd0, 1'b0, 1'b0);
    run_phase();
    apply_settings(14'd0, 14'd16383, 9'd256, 3'd7, 1'b0, 1'b0);
    run_phase();
    apply_settings(14'd3950, 14'd3850, 9'd511, 3'd4, 1'b0, 1'b0);
    idle_pct = 0;
    run_phase();
    idle_pct = 28;
    apply_settings(14'd4100, 14'd3700, 9'd1, 3'd1, 1'b1, 1'b0);
    run_phase();

    for (phase = 0; phase < 6; phase++) begin
      on_v = 14'($urandom_range(3600, 4300));
      off_v = ($urandom_range(9) == 0) ? 14'($urandom_range(16383))
                                        : on_v - 14'($urandom_range(300));
      apply_settings(on_v, off_v,
                     ($urandom_range(3) == 0) ? 9'($urandom_range(511))
                                              : 9'($urandom_range(1, 256)),
                     ($urandom_range(3) == 0) ? 3'($urandom_range(7))
                                              : 3'($urandom_range(1, 4)),
                     1'($urandom_range(1)), 1'b1);
      run_phase();
    end

    wait_drained();
    repeat (120) @(posedge clk);
    if (gauge.pending_count() != 0)
      gauge.report($sformatf("%0d readings never arrived", gauge.pending_count()));
    if (gauge.failures == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
